// ----- hw/rtl/egb_pkg.sv -----
// Shared types and constants for the epsilon-greedy bandit agent.
// Used by the controller, datapath, divider and top level; depends on nothing.
package egb_pkg;

	localparam int ARMS   = 16;
	localparam int ARM_W  = 4;
	localparam int NUM_W  = 5;
	localparam int EST_W  = 24;
	localparam int CNT_W  = 16;
	localparam int DRAW_W = 16;
	localparam int DVD_W  = 25;
	localparam int IDX_W  = 4;
	localparam int DATA_W = 16;

	localparam logic [IDX_W-1:0] REG_EPSILON     = 4'd0;
	localparam logic [IDX_W-1:0] REG_ARMS_IN_USE = 4'd1;

	localparam logic [DATA_W-1:0] EPSILON_RESET = 16'd6554;
	localparam logic [NUM_W-1:0]  ARMS_RESET    = 5'd10;

	localparam logic [1:0] DIV_SEL_UPD = 2'd0;
	localparam logic [1:0] DIV_SEL_EXP = 2'd1;
	localparam logic [1:0] DIV_SEL_TIE = 2'd2;

	typedef struct packed {
		logic                     has_reward;
		logic [ARM_W-1:0]         arm;
		logic signed [DRAW_W-1:0] reward;
		logic [DRAW_W-1:0]        explore_draw;
		logic [DRAW_W-1:0]        arm_draw;
		logic [DRAW_W-1:0]        tie_draw;
	} egb_item_t;

	typedef struct packed {
		logic [ARM_W-1:0] action;
		logic             explored;
	} egb_result_t;

	typedef struct packed {
		logic       load_item;
		logic       div_start;
		logic [1:0] div_sel;
		logic       write_upd;
		logic       scan_init;
		logic       scan1_step;
		logic       pick_load;
		logic       scan2_step;
		logic       emit_explore;
		logic       emit_greedy;
	} egb_cmd_t;

	typedef struct packed {
		logic upd_ok;
		logic explore;
		logic single_arm;
		logic last_idx;
		logic match;
	} egb_status_t;

	typedef struct packed {
		logic              wide;
		logic [DVD_W-1:0]  dividend;
		logic [CNT_W-1:0]  divisor;
	} egb_div_in_t;

endpackage

// ----- hw/rtl/egb_div.sv -----
// Restoring divider, one quotient bit per cycle, 25-bit or 16-bit dividend.
// Depends on egb_pkg for widths and the operand struct.
module egb_div import egb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  egb_div_in_t       op,
	output logic              done,
	output logic [DVD_W-1:0]  quo,
	output logic [CNT_W-1:0]  rem
);

	logic              run_q;
	logic              done_q;
	logic [NUM_W-1:0]  cnt_q;
	logic [DVD_W-1:0]  dq_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, dq_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= op.wide ? NUM_W'(DVD_W - 1) : NUM_W'(DRAW_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= op.divisor;
			dq_q  <= op.wide ? op.dividend :
				{op.dividend[DRAW_W-1:0], {(DVD_W-DRAW_W){1'b0}}};
		end else if (run_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = dq_q;
	assign rem  = rem_q;

endmodule

// ----- hw/rtl/egb_datapath.sv -----
// Datapath: registers, arm tables, estimate update, scan and result register.
// Depends on egb_pkg; the divider's operands leave here and its results return.
module egb_datapath import egb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [DATA_W-1:0] wr_data,
	input  egb_item_t         item,
	input  egb_cmd_t          cmd,
	output egb_status_t       status,
	output egb_div_in_t       div_op,
	input  logic [DVD_W-1:0]  div_quo,
	input  logic [CNT_W-1:0]  div_rem,
	output logic              done,
	output egb_result_t       result
);

	egb_item_t                item_q;
	logic [DATA_W-1:0]        eps_q;
	logic [NUM_W-1:0]         arms_q;
	logic signed [EST_W-1:0]  est_q [ARMS];
	logic [CNT_W-1:0]         cnt_q [ARMS];
	logic [ARM_W-1:0]         idx_q;
	logic signed [EST_W-1:0]  best_q;
	logic [NUM_W-1:0]         ties_q;
	logic [NUM_W-1:0]         pick_q;
	logic [NUM_W-1:0]         seen_q;
	egb_result_t              result_q;
	logic                     done_q;

	logic [NUM_W-1:0]         n_eff;
	logic [ARM_W-1:0]         n_last;
	logic signed [EST_W-1:0]  est_rd;
	logic [CNT_W-1:0]         cnt_rd;
	logic [CNT_W-1:0]         cnt_new;
	logic signed [EST_W-1:0]  target;
	logic signed [DVD_W-1:0]  diff;
	logic [DVD_W-1:0]         diff_abs;
	logic [DVD_W:0]           step;
	logic [DVD_W:0]           est_sum;
	logic                     eq_best;

	always_comb begin
		if (arms_q == '0) begin
			n_eff = NUM_W'(1);
		end else if (arms_q > NUM_W'(ARMS)) begin
			n_eff = NUM_W'(ARMS);
		end else begin
			n_eff = arms_q;
		end
	end

	assign n_last   = ARM_W'(n_eff - 1'b1);
	assign est_rd   = est_q[idx_q];
	assign cnt_rd   = cnt_q[idx_q];
	assign cnt_new  = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
	assign target   = {item_q.reward, 8'd0};
	assign diff     = {target[EST_W-1], target} - {est_rd[EST_W-1], est_rd};
	assign diff_abs = diff[DVD_W-1] ? DVD_W'(-diff) : DVD_W'(diff);
	assign step     = diff[DVD_W-1] ? -{1'b0, div_quo} : {1'b0, div_quo};
	assign est_sum  = {{2{est_rd[EST_W-1]}}, est_rd} + step;
	assign eq_best  = est_rd == best_q;

	assign status.upd_ok     = item_q.has_reward && ({1'b0, item_q.arm} < n_eff);
	assign status.explore    = item_q.explore_draw < eps_q;
	assign status.single_arm = n_eff == NUM_W'(1);
	assign status.last_idx   = idx_q == n_last;
	assign status.match      = eq_best && (seen_q == pick_q);

	always_comb begin
		div_op = '0;
		unique case (cmd.div_sel)
			DIV_SEL_UPD: begin
				div_op.wide     = 1'b1;
				div_op.dividend = diff_abs;
				div_op.divisor  = cnt_new;
			end
			DIV_SEL_EXP: begin
				div_op.dividend = DVD_W'(item_q.arm_draw);
				div_op.divisor  = CNT_W'(n_eff);
			end
			DIV_SEL_TIE: begin
				div_op.dividend = DVD_W'(item_q.tie_draw);
				div_op.divisor  = CNT_W'(ties_q);
			end
			default: begin
				div_op = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q  <= EPSILON_RESET;
			arms_q <= ARMS_RESET;
			done_q <= 1'b0;
			for (int i = 0; i < ARMS; i++) begin
				est_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			if (wr_en && wr_index == REG_EPSILON) begin
				eps_q <= wr_data;
			end
			if (wr_en && wr_index == REG_ARMS_IN_USE) begin
				arms_q <= wr_data[NUM_W-1:0];
			end
			if (cmd.write_upd) begin
				est_q[idx_q] <= est_sum[EST_W-1:0];
				cnt_q[idx_q] <= cnt_new;
			end
			done_q <= cmd.emit_explore || cmd.emit_greedy;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
			idx_q  <= item.arm;
		end
		if (cmd.scan_init) begin
			best_q <= est_q[0];
			ties_q <= NUM_W'(1);
			idx_q  <= ARM_W'(1);
		end
		if (cmd.scan1_step) begin
			if (est_rd > best_q) begin
				best_q <= est_rd;
				ties_q <= NUM_W'(1);
			end else if (eq_best) begin
				ties_q <= ties_q + 1'b1;
			end
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.pick_load) begin
			pick_q <= div_rem[NUM_W-1:0];
			seen_q <= '0;
			idx_q  <= '0;
		end
		if (cmd.scan2_step) begin
			if (eq_best) begin
				seen_q <= seen_q + 1'b1;
			end
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.emit_explore) begin
			result_q.action   <= div_rem[ARM_W-1:0];
			result_q.explored <= 1'b1;
		end
		if (cmd.emit_greedy) begin
			result_q.action   <= idx_q;
			result_q.explored <= 1'b0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- hw/rtl/egb_ctrl.sv -----
// Controller state machine sequencing update, exploration and greedy scans.
// Depends on egb_pkg for the command and status structs.
module egb_ctrl import egb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  egb_status_t status,
	input  logic        div_done,
	output egb_cmd_t    cmd,
	output logic        busy
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CHK     = 4'd1;
	localparam logic [3:0] S_DIV_UPD = 4'd2;
	localparam logic [3:0] S_WRITE   = 4'd3;
	localparam logic [3:0] S_DECIDE  = 4'd4;
	localparam logic [3:0] S_SCAN1   = 4'd5;
	localparam logic [3:0] S_TIE     = 4'd6;
	localparam logic [3:0] S_DIV_TIE = 4'd7;
	localparam logic [3:0] S_SCAN2   = 4'd8;
	localparam logic [3:0] S_DIV_EXP = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_item = 1'b1;
					state_d       = S_CHK;
				end
			end
			S_CHK: begin
				if (status.upd_ok) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SEL_UPD;
					state_d       = S_DIV_UPD;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_DIV_UPD: begin
				if (div_done) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.write_upd = 1'b1;
				state_d       = S_DECIDE;
			end
			S_DECIDE: begin
				if (status.explore) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SEL_EXP;
					state_d       = S_DIV_EXP;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = status.single_arm ? S_TIE : S_SCAN1;
				end
			end
			S_SCAN1: begin
				cmd.scan1_step = 1'b1;
				if (status.last_idx) begin
					state_d = S_TIE;
				end
			end
			S_TIE: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SEL_TIE;
				state_d       = S_DIV_TIE;
			end
			S_DIV_TIE: begin
				cmd.div_sel = DIV_SEL_TIE;
				if (div_done) begin
					cmd.pick_load = 1'b1;
					state_d       = S_SCAN2;
				end
			end
			S_SCAN2: begin
				if (status.match) begin
					cmd.emit_greedy = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.scan2_step = 1'b1;
				end
			end
			S_DIV_EXP: begin
				cmd.div_sel = DIV_SEL_EXP;
				if (div_done) begin
					cmd.emit_explore = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

// ----- hw/rtl/epsilon_greedy_bandit_agent.sv -----
// Top level of the epsilon-greedy bandit agent: controller, datapath and divider.
// Depends on egb_pkg, egb_ctrl, egb_datapath and egb_div.
//
// Channel   Direction  Handshake          Word
// item      in         start && !busy     egb_item_t
// result    out        done, one cycle    egb_result_t
// config    in         wr_en              wr_index, wr_data
//
// An item is quickest when it explores without a reward and slowest when it carries
// a reward and is chosen greedily over sixteen arms; the serial divider serves the
// estimate update and each modulo, and each greedy scan visits the arms in turn.
// Reset clears both arm tables at once; the result strobe cannot be held off, and
// a new word is taken in the cycle its predecessor's result is shown.
module epsilon_greedy_bandit_agent import egb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  egb_item_t         item,
	output logic              done,
	output egb_result_t       result,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [DATA_W-1:0] wr_data
);

	egb_cmd_t          cmd;
	egb_status_t       status;
	egb_div_in_t       div_op;
	logic              div_done;
	logic [DVD_W-1:0]  div_quo;
	logic [CNT_W-1:0]  div_rem;

	egb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.status   (status),
		.div_done (div_done),
		.cmd      (cmd),
		.busy     (busy)
	);

	egb_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item),
		.cmd      (cmd),
		.status   (status),
		.div_op   (div_op),
		.div_quo  (div_quo),
		.div_rem  (div_rem),
		.done     (done),
		.result   (result)
	);

	egb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.op     (div_op),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("Result strobe without a word in progress.");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted word did not start the sequence.");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe lasted more than one cycle.");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> busy)
		else $error("Divider started outside a word.");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for epsilon_greedy_bandit_agent: drives item words and
// register writes, predicts every arm choice and checks each result word against it.
// Depends on egb_pkg and the epsilon_greedy_bandit_agent RTL.
module testbench import egb_pkg::*;;

	localparam int IDLE_PCT [4] = '{0, 86, 0, 28};
	localparam logic [DATA_W-1:0] COMMON_REWARDS [5] =
		'{16'h0000, 16'h1000, 16'hF000, 16'h7FFF, 16'h8000};
	localparam logic [IDX_W-1:0] LAST_INDEX = '1;

	class bandit_scoreboard;
		logic [DATA_W-1:0]       epsilon;
		logic [NUM_W-1:0]        arms_cfg;
		logic signed [EST_W-1:0] estimate [ARMS];
		logic [CNT_W-1:0]        pulls [ARMS];
		egb_result_t             expected_choices [$];
		int                      errors;

		function new();
			epsilon  = EPSILON_RESET;
			arms_cfg = ARMS_RESET;
			errors   = 0;
			for (int i = 0; i < ARMS; i++) begin
				estimate[i] = '0;
				pulls[i]    = '0;
			end
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			if (idx == REG_EPSILON) begin
				epsilon = data;
			end else if (idx == REG_ARMS_IN_USE) begin
				arms_cfg = data[NUM_W-1:0];
			end
		endfunction

		function egb_result_t predict_choice(egb_item_t it);
			egb_result_t r;
			int n;
			int target;
			int est;
			int best;
			int ties;
			int pick;
			int seen;
			n = arms_cfg;
			if (n == 0) n = 1;
			if (n > ARMS) n = ARMS;
			if (it.has_reward && int'(it.arm) < n) begin
				target = int'($signed(it.reward)) * 256;
				est = int'(estimate[it.arm]);
				if (pulls[it.arm] != '1) pulls[it.arm] = pulls[it.arm] + 1'b1;
				est = est + (target - est) / int'(pulls[it.arm]);
				estimate[it.arm] = est[EST_W-1:0];
			end
			r = '0;
			if (it.explore_draw < epsilon) begin
				r.explored = 1'b1;
				r.action   = ARM_W'(int'(it.arm_draw) % n);
			end else begin
				best = int'(estimate[0]);
				ties = 1;
				for (int i = 1; i < n; i++) begin
					if (int'(estimate[i]) > best) begin
						best = int'(estimate[i]);
						ties = 1;
					end else if (int'(estimate[i]) == best) begin
						ties++;
					end
				end
				pick = int'(it.tie_draw) % ties;
				seen = 0;
				for (int i = 0; i < n; i++) begin
					if (int'(estimate[i]) == best) begin
						if (seen == pick) r.action = ARM_W'(i);
						seen++;
					end
				end
				r.explored = 1'b0;
			end
			return r;
		endfunction

		function void note_item(egb_item_t it);
			expected_choices.push_back(predict_choice(it));
		endfunction

		function void check_result(egb_result_t got);
			egb_result_t want;
			if (expected_choices.size() == 0) begin
				$error("unexpected result word: action %0d explored %0d",
					got.action, got.explored);
				errors++;
				return;
			end
			want = expected_choices.pop_front();
			if (got.action !== want.action) begin
				$error("action: expected %0d, actual %0d", want.action, got.action);
				errors++;
			end
			if (got.explored !== want.explored) begin
				$error("explored: expected %0d, actual %0d", want.explored, got.explored);
				errors++;
			end
		endfunction

		function int pending();
			return expected_choices.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	egb_item_t         item;
	logic              done;
	egb_result_t       result;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_index;
	logic [DATA_W-1:0] wr_data;

	bandit_scoreboard sb = new();

	epsilon_greedy_bandit_agent uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) sb.check_result(result);
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic egb_item_t make_item(logic hr, logic [ARM_W-1:0] a,
		logic [DRAW_W-1:0] r, logic [DRAW_W-1:0] ed, logic [DRAW_W-1:0] ad,
		logic [DRAW_W-1:0] td);
		egb_item_t it;
		it.has_reward   = hr;
		it.arm          = a;
		it.reward       = r;
		it.explore_draw = ed;
		it.arm_draw     = ad;
		it.tie_draw     = td;
		return it;
	endfunction

	function automatic egb_item_t random_item();
		egb_item_t it;
		it.has_reward = ($urandom_range(9) < 7);
		it.arm        = ARM_W'($urandom_range(ARMS - 1));
		if ($urandom_range(9) < 4) begin
			it.reward = COMMON_REWARDS[$urandom_range(4)];
		end else begin
			it.reward = DRAW_W'($urandom);
		end
		case ($urandom_range(3))
			0: begin
				it.explore_draw = '0;
			end
			1: begin
				it.explore_draw = '1;
			end
			default: begin
				it.explore_draw = DRAW_W'($urandom);
			end
		endcase
		it.arm_draw = DRAW_W'($urandom);
		it.tie_draw = DRAW_W'($urandom);
		return it;
	endfunction

	task automatic send_word(egb_item_t it);
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_item(it);
	endtask

	task automatic idle_for(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_with_gap(egb_item_t it, int pct);
		int gap = 0;
		while (gap < 200 && $urandom_range(99) < pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			do @(posedge clk); while (busy !== 1'b0);
		end
		idle_for(gap);
		send_word(it);
	endtask

	task automatic reconfigure();
		logic [DATA_W-1:0] eps;
		logic [NUM_W-1:0]  n;
		case ($urandom_range(3))
			0: begin
				eps = '0;
			end
			1: begin
				eps = '1;
			end
			default: begin
				eps = DATA_W'($urandom);
			end
		endcase
		case ($urandom_range(4))
			0: begin
				n = '0;
			end
			1: begin
				n = NUM_W'(1);
			end
			2: begin
				n = NUM_W'(ARMS);
			end
			3: begin
				n = '1;
			end
			default: begin
				n = NUM_W'($urandom_range(2, ARMS - 1));
			end
		endcase
		drain();
		write_reg(REG_EPSILON, eps);
		write_reg(REG_ARMS_IN_USE, {(DATA_W - NUM_W)'($urandom), n});
		if ($urandom_range(3) == 0) begin
			write_reg(IDX_W'($urandom_range(REG_ARMS_IN_USE + 1, LAST_INDEX)),
				DATA_W'($urandom));
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		item     = '0;
		wr_en    = 1'b0;
		wr_index = '0;
		wr_data  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: ten arms in use, epsilon of about a tenth.
		send_word(make_item(1'b0, 4'd0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
		send_word(make_item(1'b0, 4'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000));
		send_word(make_item(1'b1, 4'd0, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000));
		send_word(make_item(1'b1, 4'd1, 16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF));
		send_word(make_item(1'b1, 4'd15, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000));
		send_word(make_item(1'b1, 4'd9, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0003));
		send_word(make_item(1'b1, 4'd0, 16'h0000, EPSILON_RESET - 1'b1, 16'd12345,
			16'h0000));
		send_word(make_item(1'b0, 4'd0, 16'h0000, EPSILON_RESET, 16'h0000, 16'h0001));

		drain();
		write_reg(REG_EPSILON, 16'h0000);
		write_reg(REG_ARMS_IN_USE, 16'h0000);
		send_word(make_item(1'b1, 4'd0, 16'h1234, 16'h0000, 16'hFFFF, 16'hFFFF));
		send_word(make_item(1'b1, 4'd1, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF));

		drain();
		write_reg(REG_EPSILON, 16'hFFFF);
		write_reg(REG_ARMS_IN_USE, 16'hFFFF);
		send_word(make_item(1'b1, 4'd15, 16'h4000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_word(make_item(1'b0, 4'd0, 16'h0000, 16'hFFFE, 16'hFFFF, 16'h0000));
		send_word(make_item(1'b1, 4'd15, 16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF));

		drain();
		write_reg(REG_ARMS_IN_USE + 1'b1, 16'hFFFF);
		write_reg(LAST_INDEX, 16'h0000);
		send_word(make_item(1'b0, 4'd0, 16'h0000, 16'hFFFE, 16'h0007, 16'h0000));
		send_word(make_item(1'b1, 4'd7, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000));

		for (int phase = 0; phase < 4; phase++) begin
			for (int blk = 0; blk < 4; blk++) begin
				reconfigure();
				for (int k = 0; k < 50; k++) begin
					if ($urandom_range(49) == 0) drain();
					send_with_gap(random_item(), IDLE_PCT[phase]);
				end
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
